// ----- rtl/dtps_pkg.sv -----
// shared types and constants for the dag task placement scheduler
package dtps_pkg;

    localparam int FT_W = 16;
    localparam int EN_W = 18;
    localparam logic [FT_W-1:0] FT_MAX = 16'hFFFF;
    localparam logic [EN_W-1:0] EN_MAX = 18'h3FFFF;

    // configuration register indexes
    localparam logic [2:0] REG_SEND_TIME    = 3'd0;
    localparam logic [2:0] REG_CLOUD_TIME   = 3'd1;
    localparam logic [2:0] REG_RECV_TIME    = 3'd2;
    localparam logic [2:0] REG_SEND_POWER   = 3'd3;
    localparam logic [2:0] REG_CORE1_POWER  = 3'd4;
    localparam logic [2:0] REG_CORE2_POWER  = 3'd5;
    localparam logic [2:0] REG_CORE3_POWER  = 3'd6;

    // placement codes
    localparam logic [1:0] PLACE_CLOUD = 2'd0;
    localparam logic [1:0] PLACE_CORE1 = 2'd1;
    localparam logic [1:0] PLACE_CORE2 = 2'd2;
    localparam logic [1:0] PLACE_CORE3 = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_REMOTE,
        ST_PRIO,
        ST_SORT,
        ST_SCHED_SCAN,
        ST_SCHED_CAND,
        ST_SCHED_PICK,
        ST_TOTAL,
        ST_EMIT
    } state_t;

    // saturating add onto a finish time
    function automatic logic [FT_W-1:0] sat_add(input logic [FT_W-1:0] a,
                                                input logic [FT_W-1:0] b);
        logic [FT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FT_W] ? FT_MAX : s[FT_W-1:0];
    endfunction

endpackage

// ----- rtl/dag_task_placement_scheduler_core.sv -----
// top level: task store, sequencer and add/compare datapath
//
//  channel  | signals                                         | transfer
//  ---------+-------------------------------------------------+---------------------
//  task in  | start busy successor_mask core_*_run_time ...   | start & !busy
//  config   | cfg_valid cfg_ready cfg_index cfg_data          | cfg_valid & cfg_ready
//  result   | result_valid task_id placement finish_time ...  | result_valid
//
// loading takes one task per accepted start; the last task starts scheduling.
// scheduling then steps through the task store in order: the remote marks,
// the priorities, the ordering, the placement, the total time and the results.
// reset clears the sequencer, task count and channel state; the stores need none.
// results cannot be stalled; busy stays high until the last one is out.
module dag_task_placement_scheduler_core
    import dtps_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] successor_mask,
    input  logic [7:0]  core_one_run_time,
    input  logic [7:0]  core_two_run_time,
    input  logic [7:0]  core_three_run_time,
    input  logic        is_entry_task,
    input  logic        last_task,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    output logic        result_valid,
    output logic [3:0]  task_id,
    output logic [1:0]  placement,
    output logic [15:0] finish_time,
    output logic [15:0] total_time,
    output logic [17:0] total_energy_halves,
    output logic        last_result
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [5:0] send_time, cloud_time, receive_time;
    logic [3:0] send_pow, pow1, pow2, pow3;

    assign cfg_ready = 1'b1;

    dtps_cfg_regs u_cfg (
        .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
        .send_time, .cloud_time, .receive_time,
        .send_pow, .pow1, .pow2, .pow3
    );

    // task store
    logic [15:0]     succ_mem   [MAX_TASKS];
    logic [7:0]      t1_mem     [MAX_TASKS];
    logic [7:0]      t2_mem     [MAX_TASKS];
    logic [7:0]      t3_mem     [MAX_TASKS];
    logic            entry_mem  [MAX_TASKS];
    logic            remote_mem [MAX_TASKS];
    logic [15:0]     prio_mem   [MAX_TASKS];
    logic [IW-1:0]   seq_mem    [MAX_TASKS];
    logic [1:0]      place_mem  [MAX_TASKS];
    logic [15:0]     fin_mem    [MAX_TASKS];
    logic [MAX_TASKS-1:0] taken_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic [15:0]   acc_a_reg, acc_b_reg;
    logic          found_reg;
    logic [IW-1:0] pick_reg;
    logic [15:0]   c1_reg, c2_reg, c3_reg, ws_reg, cl_reg, wr_reg;
    logic [EN_W-1:0] energy_reg;
    logic [15:0]   total_reg;

    logic [IW-1:0] n_last;
    logic          accept;
    logic          store_full;
    logic [IW-1:0] cur;

    assign accept     = start && !busy;
    assign store_full = (count_reg == CW'(MAX_TASKS));
    assign n_last     = IW'(count_reg - CW'(1));
    assign cur        = seq_mem[k_reg];
    assign busy       = (state_reg != ST_LOAD);

    // shared arithmetic: t_re and the edge test
    logic [7:0] t_re;
    logic [15:0] w3;
    logic        edge_ij;   // i is predecessor of j (for priority walk)
    logic        edge_jc;   // j is predecessor of cur
    logic [7:0]  ct1, ct2, ct3, ctmin;
    assign t_re = 8'(send_time) + 8'(cloud_time) + 8'(receive_time);
    assign ct1 = t1_mem[i_reg];
    assign ct2 = t2_mem[i_reg];
    assign ct3 = t3_mem[i_reg];
    assign ctmin = (ct1 < ct2) ? ((ct1 < ct3) ? ct1 : ct3) : ((ct2 < ct3) ? ct2 : ct3);
    assign w3 = remote_mem[i_reg] ? 16'(3 * t_re) : 16'(ct1) + 16'(ct2) + 16'(ct3);

    always_comb
    begin
        edge_ij = (32'(j_reg) < 32'd16) && (j_reg > i_reg) &&
                  succ_mem[i_reg][4'(j_reg)];
        edge_jc = (32'(cur) < 32'd16) && (j_reg < cur) &&
                  succ_mem[j_reg][4'(cur)];
    end

    // ordering step: current task beats the pick so far
    logic sort_win;
    assign sort_win = !taken_reg[i_reg] &&
                      (!found_reg || prio_mem[i_reg] > prio_mem[pick_reg]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:       if (accept && last_task) state_next = ST_REMOTE;
            ST_REMOTE:     if (i_reg == n_last) state_next = ST_PRIO;
            ST_PRIO:       if (i_reg == '0 && j_reg >= n_last) state_next = ST_SORT;
            ST_SORT:       if (i_reg == n_last && k_reg == n_last) state_next = ST_SCHED_SCAN;
            ST_SCHED_SCAN: if (j_reg == n_last) state_next = ST_SCHED_CAND;
            ST_SCHED_CAND: state_next = ST_SCHED_PICK;
            ST_SCHED_PICK: if (k_reg == n_last) state_next = ST_TOTAL;
                           else state_next = ST_SCHED_SCAN;
            ST_TOTAL:      if (i_reg == n_last) state_next = ST_EMIT;
            ST_EMIT:       if (i_reg == n_last) state_next = ST_LOAD;
            default:       state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    // candidate finish times, registered in the candidate step
    // acc_a: latest finish of any predecessor; acc_b: of local predecessors
    logic [15:0] f0_reg, f1_reg, f2_reg, f3_reg;
    logic [15:0] rl_max;
    assign rl_max = acc_a_reg;

    // uplink ready point: local tasks always wait for WS, remote ones only
    // behind a cloud predecessor
    logic [15:0] rs_val;
    assign rs_val = (remote_mem[cur] && !found_reg) ? acc_b_reg :
                    ((ws_reg > acc_b_reg) ? ws_reg : acc_b_reg);

    // remote chain: f0 holds the new WS
    logic [15:0] rc_val, cl_val, wr_val;
    assign rc_val = (found_reg && cl_reg > f0_reg) ? cl_reg : f0_reg;
    assign cl_val = sat_add(rc_val, 16'(cloud_time));
    assign wr_val = sat_add(cl_val, 16'(receive_time));

    logic [1:0]  sel;
    logic [15:0] best;
    always_comb
    begin
        if (entry_mem[cur] || remote_mem[cur])
        begin
            sel = PLACE_CORE1;
            best = f1_reg;
        end
        else
        begin
            sel = PLACE_CLOUD;
            best = f0_reg;
        end
        if (f1_reg < best && sel == PLACE_CLOUD)
        begin
            sel = PLACE_CORE1;
            best = f1_reg;
        end
        if (f2_reg < best)
        begin
            sel = PLACE_CORE2;
            best = f2_reg;
        end
        if (f3_reg < best)
        begin
            sel = PLACE_CORE3;
            best = f3_reg;
        end
        if (remote_mem[cur])
            sel = PLACE_CLOUD;
    end

    logic [EN_W-1:0] e_add;
    always_comb
    begin
        unique case (sel)
            PLACE_CORE1: e_add = EN_W'(pow1) * EN_W'(t1_mem[cur]);
            PLACE_CORE2: e_add = EN_W'(pow2) * EN_W'(t2_mem[cur]);
            PLACE_CORE3: e_add = EN_W'(pow3) * EN_W'(t3_mem[cur]);
            PLACE_CLOUD: e_add = EN_W'(send_pow) * EN_W'(send_time);
        endcase
    end

    logic [EN_W:0] e_sum;
    assign e_sum = {1'b0, energy_reg} + {1'b0, e_add};

    // datapath and sequencer counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            pick_reg   <= '0;
            found_reg  <= 1'b0;
            taken_reg  <= '0;
            acc_a_reg  <= '0;
            acc_b_reg  <= '0;
            f0_reg <= '0; f1_reg <= '0; f2_reg <= '0; f3_reg <= '0;
            c1_reg <= '0; c2_reg <= '0; c3_reg <= '0;
            ws_reg <= '0; cl_reg <= '0; wr_reg <= '0;
            energy_reg <= '0;
            total_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (!store_full)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        i_reg <= '0;
                    end
                end
                ST_REMOTE:
                begin
                    if (i_reg == n_last)
                    begin
                        i_reg <= n_last;
                        j_reg <= n_last;
                        acc_a_reg <= '0;
                    end
                    else
                        i_reg <= i_reg + IW'(1);
                end
                ST_PRIO:
                begin
                    if (j_reg >= n_last)
                    begin
                        acc_a_reg <= '0;
                        if (i_reg == '0)
                        begin
                            k_reg <= '0;
                            found_reg <= 1'b0;
                            taken_reg <= '0;
                        end
                        else
                        begin
                            i_reg <= i_reg - IW'(1);
                            j_reg <= i_reg;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + IW'(1);
                        if (edge_ij && prio_mem[j_reg] > acc_a_reg)
                            acc_a_reg <= prio_mem[j_reg];
                    end
                end
                ST_SORT:
                begin
                    if (i_reg == n_last)
                    begin
                        i_reg <= '0;
                        found_reg <= 1'b0;
                        taken_reg[sort_win ? i_reg : pick_reg] <= 1'b1;
                        if (k_reg == n_last)
                        begin
                            k_reg <= '0;
                            j_reg <= '0;
                            acc_a_reg <= '0;
                            acc_b_reg <= '0;
                        end
                        else
                            k_reg <= k_reg + IW'(1);
                    end
                    else
                    begin
                        i_reg <= i_reg + IW'(1);
                        if (sort_win)
                        begin
                            pick_reg <= i_reg;
                            found_reg <= 1'b1;
                        end
                    end
                end
                ST_SCHED_SCAN:
                begin
                    // found_reg: a cloud predecessor was seen
                    if (k_reg == '0 && j_reg == '0)
                    begin
                        c1_reg <= '0; c2_reg <= '0; c3_reg <= '0;
                        ws_reg <= '0; cl_reg <= '0; wr_reg <= '0;
                        energy_reg <= '0;
                    end
                    if (edge_jc)
                    begin
                        if (fin_mem[j_reg] > acc_a_reg)
                            acc_a_reg <= fin_mem[j_reg];
                        if (place_mem[j_reg] == PLACE_CLOUD)
                            found_reg <= 1'b1;
                        else if (fin_mem[j_reg] > acc_b_reg)
                            acc_b_reg <= fin_mem[j_reg];
                    end
                    if (j_reg != n_last)
                        j_reg <= j_reg + IW'(1);
                end
                ST_SCHED_CAND:
                begin
                    f0_reg <= sat_add(rs_val, remote_mem[cur] ? 16'(send_time) :
                                      16'(t_re));
                    f1_reg <= sat_add((rl_max > c1_reg) ? rl_max : c1_reg,
                                      16'(t1_mem[cur]));
                    f2_reg <= sat_add((rl_max > c2_reg) ? rl_max : c2_reg,
                                      16'(t2_mem[cur]));
                    f3_reg <= sat_add((rl_max > c3_reg) ? rl_max : c3_reg,
                                      16'(t3_mem[cur]));
                end
                ST_SCHED_PICK:
                begin
                    energy_reg <= e_sum[EN_W] ? EN_MAX : e_sum[EN_W-1:0];
                    if (remote_mem[cur])
                    begin
                        ws_reg <= f0_reg;
                        cl_reg <= cl_val;
                        wr_reg <= wr_val;
                    end
                    else if (sel == PLACE_CLOUD)
                    begin
                        wr_reg <= best;
                        cl_reg <= best - 16'(receive_time);
                        ws_reg <= best - 16'(receive_time) - 16'(cloud_time);
                    end
                    else if (sel == PLACE_CORE1)
                        c1_reg <= best;
                    else if (sel == PLACE_CORE2)
                        c2_reg <= best;
                    else
                        c3_reg <= best;
                    j_reg <= '0;
                    acc_a_reg <= '0;
                    acc_b_reg <= '0;
                    found_reg <= 1'b0;
                    if (k_reg == n_last)
                    begin
                        i_reg <= '0;
                        total_reg <= '0;
                    end
                    else
                        k_reg <= k_reg + IW'(1);
                end
                ST_TOTAL:
                begin
                    if (fin_mem[i_reg] > total_reg)
                        total_reg <= fin_mem[i_reg];
                    i_reg <= (i_reg == n_last) ? '0 : i_reg + IW'(1);
                end
                ST_EMIT:
                begin
                    if (i_reg == n_last)
                    begin
                        count_reg <= '0;
                        energy_reg <= '0;
                    end
                    else
                        i_reg <= i_reg + IW'(1);
                end
                default: ;
            endcase
        end
    end

    // stores written in clocked blocks
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && accept && !store_full)
        begin
            succ_mem[IW'(count_reg)]  <= successor_mask;
            t1_mem[IW'(count_reg)]    <= core_one_run_time;
            t2_mem[IW'(count_reg)]    <= core_two_run_time;
            t3_mem[IW'(count_reg)]    <= core_three_run_time;
            entry_mem[IW'(count_reg)] <= is_entry_task;
        end
        if (state_reg == ST_REMOTE)
            remote_mem[i_reg] <= (t_re < ctmin) && !entry_mem[i_reg];
        if (state_reg == ST_PRIO && j_reg >= n_last)
        begin
            if (j_reg > i_reg && edge_ij && prio_mem[j_reg] > acc_a_reg)
                prio_mem[i_reg] <= sat_add(w3, prio_mem[j_reg]);
            else
                prio_mem[i_reg] <= sat_add(w3, acc_a_reg);
        end
        if (state_reg == ST_SORT && i_reg == n_last)
            seq_mem[k_reg] <= sort_win ? i_reg : pick_reg;
        if (state_reg == ST_SCHED_PICK)
        begin
            place_mem[cur] <= sel;
            fin_mem[cur]   <= remote_mem[cur] ? wr_val : best;
        end
    end

    // outputs
    assign result_valid        = (state_reg == ST_EMIT);
    assign task_id             = 4'(i_reg);
    assign placement           = place_mem[i_reg];
    assign finish_time         = fin_mem[i_reg];
    assign total_time          = total_reg;
    assign total_energy_halves = energy_reg;
    assign last_result         = (i_reg == n_last);

    // assertions
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result while idle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TASKS))
        else $error("task count overflow");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |=> !busy)
        else $error("busy after last result");

endmodule

// ----- rtl/dtps_cfg_regs.sv -----
// configuration register file of the scheduler
module dtps_cfg_regs
    import dtps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [2:0] cfg_index,
    input  logic [5:0] cfg_data,
    output logic [5:0] send_time,
    output logic [5:0] cloud_time,
    output logic [5:0] receive_time,
    output logic [3:0] send_pow,
    output logic [3:0] pow1,
    output logic [3:0] pow2,
    output logic [3:0] pow3
);

    logic [5:0] send_reg, cloud_reg, recv_reg;
    logic [3:0] spow_reg, p1_reg, p2_reg, p3_reg;

    // register writes, one per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_reg  <= 6'd3;
            cloud_reg <= 6'd1;
            recv_reg  <= 6'd1;
            spow_reg  <= 4'd1;
            p1_reg    <= 4'd2;
            p2_reg    <= 4'd4;
            p3_reg    <= 4'd8;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SEND_TIME:   send_reg  <= cfg_data;
                REG_CLOUD_TIME:  cloud_reg <= cfg_data;
                REG_RECV_TIME:   recv_reg  <= cfg_data;
                REG_SEND_POWER:  spow_reg  <= cfg_data[3:0];
                REG_CORE1_POWER: p1_reg    <= cfg_data[3:0];
                REG_CORE2_POWER: p2_reg    <= cfg_data[3:0];
                REG_CORE3_POWER: p3_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign send_time    = send_reg;
    assign cloud_time   = cloud_reg;
    assign receive_time = recv_reg;
    assign send_pow     = spow_reg;
    assign pow1         = p1_reg;
    assign pow2         = p2_reg;
    assign pow3         = p3_reg;

endmodule
